/* src/frame_receive_classifier_defines.svh */
// Assertion helpers for the receive classifier
`ifndef FRAME_RECEIVE_CLASSIFIER_DEFINES_SVH
`define FRAME_RECEIVE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, clocked on clk, held off during reset
`define FRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/frc_pkg.sv */
package frc_pkg;

    localparam int MAX_FRAME_DEFAULT = 4096;

    localparam logic [7:0] FLAG_BYTE = 8'hFE;
    localparam logic [7:0] ESC_BYTE  = 8'h5D;
    localparam logic [7:0] ADDR_EMIT = 8'h03;
    localparam logic [7:0] ADDR_PEER = 8'h01;
    localparam logic [7:0] C_SET     = 8'h03;
    localparam logic [7:0] C_UA      = 8'h07;
    localparam logic [7:0] C_DISC    = 8'h0B;
    localparam logic [7:0] C_RR1     = 8'h85;
    localparam logic [7:0] C_RR0     = 8'h05;

    localparam logic [2:0] VERDICT_REJECT = 3'd0;
    localparam logic [2:0] VERDICT_PEER   = 3'd1;
    localparam logic [2:0] VERDICT_EMIT   = 3'd2;
    localparam logic [2:0] VERDICT_SET    = 3'd3;
    localparam logic [2:0] VERDICT_DATA   = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [2:0] verdict;
    } item_t;

    // up to two results per accepted beat
    typedef struct packed {
        logic [1:0] n;
        item_t      item0;
        item_t      item1;
    } push_t;

    typedef struct packed {
        logic              nonempty;
        logic              room2;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

/* src/frame_receive_classifier.sv */
// Byte-stuffed frame receiver. One line beat (a byte, or an idle mark on
// timeout) is taken per clock while in_stall is low; in_stall rises only when
// the four-entry result queue has fewer than two free slots. Each beat is
// deframed and checked in the cycle it is taken and yields zero, one or two
// results: payload bytes one unit behind (the trailer is never shown) and one
// verdict beat, with last set, closing each frame. Results leave one per clock
// while out_stall is low, from a registered output; each result is written
// into the queue, then loaded into the output register.
`include "frame_receive_classifier_defines.svh"

module frame_receive_classifier #(
    parameter int MAX_FRAME = frc_pkg::MAX_FRAME_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       line_idle,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] payload_byte,
    output logic [2:0] verdict,
    output logic       last
);
    import frc_pkg::*;

    push_t     push;
    item_t     head;
    item_t     out_item;
    q_status_t q_st;
    logic      pop;
    logic      accept;
    logic      q_overrun;
    logic      verdict_ok;

    assign in_stall = !q_st.room2;
    assign accept   = in_valid && !in_stall;

    frc_front #(
        .MAX_FRAME(MAX_FRAME)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .line_idle(line_idle),
        .push     (push)
    );

    frc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .status(q_st)
    );

    frc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_st),
        .head     (head),
        .pop      (pop),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .out_item (out_item)
    );

    assign kind         = out_item.kind;
    assign payload_byte = out_item.payload_byte;
    assign verdict      = out_item.verdict;
    assign last         = out_item.kind;

    assign q_overrun  = (q_st.count + QCNT_W'(push.n)) > QCNT_W'(QUEUE_DEPTH);
    assign verdict_ok = (payload_byte == 8'd0) && (verdict <= VERDICT_DATA);

    `FRC_ASSERT_NOW(a_queue_bound, push.n != 2'd0, !q_overrun, "result queue overrun")
    `FRC_ASSERT_NOW(a_no_push_idle, !accept, push.n == 2'd0, "result without accepted beat")
    `FRC_ASSERT_NEXT(a_pop_fills, pop, out_valid, "popped result not presented")
    `FRC_ASSERT_NOW(a_verdict_clean, out_valid && kind, verdict_ok, "malformed verdict beat")

endmodule

/* src/frc_front.sv */
module frc_front #(
    parameter int MAX_FRAME = frc_pkg::MAX_FRAME_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    input  logic          line_idle,
    output frc_pkg::push_t push
);
    import frc_pkg::*;

    localparam int LEN_W = $clog2(MAX_FRAME + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME);
    localparam logic [LEN_W-1:0] LEN_SUP = LEN_W'(4);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'b01,
        PH_FRAME = 2'b10
    } phase_t;

    typedef struct packed {
        logic [1:0]       hc;
        logic [7:0]       addr;
        logic [7:0]       ctrl;
        logic [7:0]       hsum;
        logic [7:0]       bsum;
        logic [LEN_W-1:0] len;
    } frm_t;

    localparam frm_t FRM_CLEAR = '0;

    phase_t     phase_reg, phase_next;
    frm_t       frm_reg, frm_next;
    logic       fp_reg, fp_next;
    logic       hv_reg, hv_next;
    logic [7:0] hb_reg, hb_next;

    function automatic frm_t commit(input frm_t s, input logic [7:0] b);
        frm_t r;
        r = s;
        if (s.len < LEN_MAX)
            r.len = s.len + 1'b1;
        if (s.hc != 2'd3)
        begin
            r.hsum = s.hsum + b;
            if (s.hc == 2'd0)
                r.addr = b;
            else if (s.hc == 2'd1)
                r.ctrl = b;
            r.hc = s.hc + 2'd1;
        end
        else
            r.bsum = s.bsum + b;
        return r;
    endfunction

    function automatic logic [2:0] judge(input frm_t s);
        logic [2:0] v;
        v = VERDICT_REJECT;
        if (s.len < LEN_SUP || s.len >= LEN_MAX)
            v = VERDICT_REJECT;
        else if (s.len == LEN_SUP)
        begin
            // supervisory: closing flag is the fifth byte of the sum
            if (8'(s.hsum + FLAG_BYTE) == 8'd0)
            begin
                if (s.addr == ADDR_PEER && (s.ctrl inside {C_UA, C_DISC, C_RR1, C_RR0}))
                    v = VERDICT_PEER;
                else if (s.addr == ADDR_EMIT && (s.ctrl inside {C_DISC, C_UA}))
                    v = VERDICT_EMIT;
                else if (s.addr == ADDR_EMIT && s.ctrl == C_SET)
                    v = VERDICT_SET;
            end
        end
        else if (s.hsum == 8'd0 && s.addr == ADDR_EMIT && s.bsum == 8'd0)
            v = VERDICT_DATA;
        return v;
    endfunction

    logic       do_push;
    logic [7:0] push_val;
    logic       do_close;
    logic [2:0] close_ver;
    frm_t       s1;

    always_comb
    begin
        phase_next = phase_reg;
        frm_next   = frm_reg;
        fp_next    = fp_reg;
        do_push    = 1'b0;
        push_val   = rx_byte;
        do_close   = 1'b0;
        close_ver  = VERDICT_REJECT;
        s1         = commit(frm_reg, FLAG_BYTE);

        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (!line_idle && rx_byte == FLAG_BYTE)
                    begin
                        phase_next    = PH_FRAME;
                        frm_next      = FRM_CLEAR;
                        frm_next.hsum = FLAG_BYTE;
                        frm_next.len  = LEN_W'(1);
                    end
                end
                PH_FRAME:
                begin
                    if (line_idle)
                    begin
                        do_close  = 1'b1;
                        close_ver = fp_reg ? judge(frm_reg) : VERDICT_REJECT;
                    end
                    else if (fp_reg)
                    begin
                        if (rx_byte == ESC_BYTE)
                        begin
                            frm_next = commit(s1, ESC_BYTE);
                            fp_next  = 1'b0;
                            if (frm_reg.hc == 2'd3)
                            begin
                                do_push  = 1'b1;
                                push_val = FLAG_BYTE;
                            end
                            else if (s1.hc == 2'd3)
                            begin
                                // escape flag landed on last header byte
                                do_push  = 1'b1;
                                push_val = ESC_BYTE;
                            end
                        end
                        else if (rx_byte == FLAG_BYTE)
                        begin
                            frm_next = s1;
                            do_push  = (frm_reg.hc == 2'd3);
                            push_val = FLAG_BYTE;
                        end
                        else
                        begin
                            do_close  = 1'b1;
                            close_ver = judge(frm_reg);
                        end
                    end
                    else if (rx_byte == FLAG_BYTE)
                        fp_next = 1'b1;
                    else
                    begin
                        frm_next = commit(frm_reg, rx_byte);
                        do_push  = (frm_reg.hc == 2'd3);
                    end

                    // over-long: drop the frame
                    if (!do_close && frm_next.len >= LEN_MAX)
                    begin
                        do_close  = 1'b1;
                        close_ver = VERDICT_REJECT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        if (do_close)
        begin
            phase_next = PH_HUNT;
            frm_next   = FRM_CLEAR;
            fp_next    = 1'b0;
        end
    end

    logic emit_held;
    assign emit_held = do_push && hv_reg;

    always_comb
    begin
        hv_next = hv_reg;
        hb_next = hb_reg;
        if (do_push)
        begin
            hv_next = 1'b1;
            hb_next = push_val;
        end
        if (do_close)
            hv_next = 1'b0;
    end

    item_t held_item, verdict_item;
    always_comb
    begin
        held_item.kind            = KIND_PAYLOAD;
        held_item.payload_byte    = hb_reg;
        held_item.verdict         = VERDICT_REJECT;
        verdict_item.kind         = KIND_VERDICT;
        verdict_item.payload_byte = 8'd0;
        verdict_item.verdict      = close_ver;
        push.n     = {1'b0, emit_held} + {1'b0, do_close};
        push.item0 = emit_held ? held_item : verdict_item;
        push.item1 = verdict_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            frm_reg   <= FRM_CLEAR;
            fp_reg    <= 1'b0;
            hv_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            frm_reg   <= frm_next;
            fp_reg    <= fp_next;
            hv_reg    <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hb_reg <= hb_next;
    end

endmodule

/* src/frc_queue.sv */
module frc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  frc_pkg::push_t     push,
    input  logic               pop,
    output frc_pkg::item_t     head,
    output frc_pkg::q_status_t status
);
    import frc_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QPTR_W-1:0] wr_plus1;

    assign wr_plus1 = wr_reg + 1'b1;
    assign wr_next  = wr_reg + QPTR_W'(push.n);
    assign rd_next  = rd_reg + QPTR_W'(pop);
    assign cnt_next = QCNT_W'(cnt_reg + QCNT_W'(push.n) - QCNT_W'(pop));

    assign head            = slot_reg[rd_reg];
    assign status.nonempty = (cnt_reg != '0);
    assign status.room2    = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign status.count    = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            slot_reg[wr_reg] <= push.item0;
        if (push.n == 2'd2)
            slot_reg[wr_plus1] <= push.item1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/frc_back.sv */
module frc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  frc_pkg::q_status_t q_status,
    input  frc_pkg::item_t     head,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output frc_pkg::item_t     out_item
);
    import frc_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;

    // output register refills, when the queue holds a result, whenever it is empty or its beat is taken
    assign pop        = q_status.nonempty && (!valid_reg || !out_stall);
    assign valid_next = pop ? 1'b1 : (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign out_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head;
    end

endmodule

/* sim/frame_receive_classifier_checker.sv */
`timescale 1ns / 1ps

module frame_receive_classifier_checker #(
    parameter int MAX_FRAME = frc_pkg::MAX_FRAME_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       line_idle,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       kind,
    input  logic [7:0] payload_byte,
    input  logic [2:0] verdict,
    input  logic       last,
    output int         mismatches,
    output int         outstanding
);
    import frc_pkg::*;

    // deframer state, mirrored beat by beat
    logic        in_frame  = 1'b0;
    logic [2:0]  hdr_count = 3'd0;
    logic [7:0]  addr_seen = 8'h00;
    logic [7:0]  ctrl_seen = 8'h00;
    logic [7:0]  hdr_sum   = 8'h00;
    logic [7:0]  body_sum  = 8'h00;
    logic        flag_wait = 1'b0;
    logic        unit_held = 1'b0;
    logic [7:0]  unit_byte = 8'h00;
    int unsigned raw_count = 0;

    item_t expected_items[$];

    task automatic report_mismatch(input string what);
        if (mismatches < 100)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic frame_clear();
        in_frame  = 1'b0;
        hdr_count = 3'd0;
        addr_seen = 8'h00;
        ctrl_seen = 8'h00;
        hdr_sum   = 8'h00;
        body_sum  = 8'h00;
        flag_wait = 1'b0;
        unit_held = 1'b0;
        unit_byte = 8'h00;
        raw_count = 0;
    endtask

    // one raw data byte into the sums; in_body is low while still in the header
    task automatic take_raw(input logic [7:0] b, output logic in_body);
        if (raw_count < MAX_FRAME)
            raw_count++;
        if (hdr_count < 3'd3)
        begin
            hdr_sum = hdr_sum + b;
            if (hdr_count == 3'd0)
                addr_seen = b;
            else if (hdr_count == 3'd1)
                ctrl_seen = b;
            hdr_count = hdr_count + 3'd1;
            in_body = 1'b0;
        end
        else
        begin
            body_sum = body_sum + b;
            in_body = 1'b1;
        end
    endtask

    // payload runs one unit behind, so the trailer is never released
    task automatic hold_unit(input logic [7:0] v);
        item_t it;
        if (unit_held)
        begin
            it.kind         = KIND_PAYLOAD;
            it.payload_byte = unit_byte;
            it.verdict      = VERDICT_REJECT;
            expected_items.push_back(it);
        end
        unit_byte = v;
        unit_held = 1'b1;
    endtask

    function automatic logic [2:0] frame_verdict();
        int unsigned span;
        logic [7:0]  five_sum;
        span     = raw_count + 1;
        five_sum = hdr_sum + FLAG_BYTE;
        if (span < 5 || span > MAX_FRAME)
            return VERDICT_REJECT;
        if (span == 5)
        begin
            if (five_sum != 8'h00)
                return VERDICT_REJECT;
            if (addr_seen == ADDR_PEER && (ctrl_seen == C_UA || ctrl_seen == C_DISC ||
                                           ctrl_seen == C_RR1 || ctrl_seen == C_RR0))
                return VERDICT_PEER;
            if (addr_seen == ADDR_EMIT && (ctrl_seen == C_DISC || ctrl_seen == C_UA))
                return VERDICT_EMIT;
            if (addr_seen == ADDR_EMIT && ctrl_seen == C_SET)
                return VERDICT_SET;
            return VERDICT_REJECT;
        end
        if (hdr_sum == 8'h00 && addr_seen == ADDR_EMIT && body_sum == 8'h00)
            return VERDICT_DATA;
        return VERDICT_REJECT;
    endfunction

    task automatic close_frame(input logic [2:0] v);
        item_t it;
        it.kind         = KIND_VERDICT;
        it.payload_byte = 8'h00;
        it.verdict      = v;
        expected_items.push_back(it);
        frame_clear();
    endtask

    task automatic deframe_beat(input logic [7:0] b, input logic idle);
        logic first;
        logic second;
        if (!in_frame)
        begin
            if (!idle && b == FLAG_BYTE)
            begin
                frame_clear();
                in_frame  = 1'b1;
                raw_count = 1;
                hdr_sum   = FLAG_BYTE;
            end
            return;
        end
        if (idle)
        begin
            // timeout with no closing flag is a reject
            close_frame(flag_wait ? frame_verdict() : VERDICT_REJECT);
            return;
        end
        if (flag_wait)
        begin
            if (b == ESC_BYTE)
            begin
                take_raw(FLAG_BYTE, first);
                take_raw(ESC_BYTE, second);
                if (first)
                    hold_unit(FLAG_BYTE);
                else if (second)
                    hold_unit(ESC_BYTE);
                flag_wait = 1'b0;
            end
            else if (b == FLAG_BYTE)
            begin
                // double flag: first one is data, second stays pending
                take_raw(FLAG_BYTE, first);
                if (first)
                    hold_unit(FLAG_BYTE);
            end
            else
            begin
                close_frame(frame_verdict());
                return;
            end
        end
        else if (b == FLAG_BYTE)
            flag_wait = 1'b1;
        else
        begin
            take_raw(b, first);
            if (first)
                hold_unit(b);
        end
        if (raw_count >= MAX_FRAME)
            close_frame(VERDICT_REJECT);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t want;
        if (!rst_n)
        begin
            frame_clear();
            expected_items.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                deframe_beat(rx_byte, line_idle);
            if (out_valid && !out_stall)
            begin
                if (expected_items.size() == 0)
                    report_mismatch($sformatf("unexpected beat kind=%0b byte=%02h verdict=%0d",
                                              kind, payload_byte, verdict));
                else
                begin
                    want = expected_items.pop_front();
                    if (kind !== want.kind)
                        report_mismatch($sformatf("kind %0b, want %0b", kind, want.kind));
                    if (payload_byte !== want.payload_byte)
                        report_mismatch($sformatf("payload_byte %02h, want %02h",
                                                  payload_byte, want.payload_byte));
                    if (verdict !== want.verdict)
                        report_mismatch($sformatf("verdict %0d, want %0d",
                                                  verdict, want.verdict));
                    if (last !== want.kind)
                        report_mismatch($sformatf("last %0b, want %0b", last, want.kind));
                end
            end
        end
        outstanding = expected_items.size();
    end

endmodule

/* sim/frame_receive_classifier_tb.sv */
`timescale 1ns / 1ps

module frame_receive_classifier_tb;
    import frc_pkg::*;

    localparam int FRAME_LIMIT  = MAX_FRAME_DEFAULT;
    localparam int RANDOM_BEATS = 1800;
    localparam int HOLD_CYCLES  = 300;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       line_idle = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] verdict;
    logic       last;

    int mismatches;
    int outstanding;

    bit calm       = 1'b0;
    int hold_asked = 0;
    int hold_given = 0;
    int hold_left  = 0;
    int beats_sent = 0;

    // line beats waiting to go out: {idle mark, byte}
    logic [8:0] line_q[$];

    always #5 clk = ~clk;

    frame_receive_classifier #(
        .MAX_FRAME(FRAME_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .line_idle    (line_idle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .verdict      (verdict),
        .last         (last)
    );

    frame_receive_classifier_checker #(
        .MAX_FRAME(FRAME_LIMIT)
    ) u_frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .line_idle    (line_idle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .verdict      (verdict),
        .last         (last),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // result side: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_given != hold_asked)
        begin
            out_stall  <= 1'b1;
            hold_given <= hold_given + 1;
            hold_left  <= HOLD_CYCLES;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end

    function automatic logic [7:0] header_check(input logic [7:0] a, input logic [7:0] c);
        return 8'h00 - FLAG_BYTE - a - c;
    endfunction

    // bytes leaning towards flag, escape and address values
    function automatic logic [7:0] skewed_byte();
        case ($urandom_range(0, 5))
            0, 1:    return FLAG_BYTE;
            2:       return ESC_BYTE;
            3:       return ADDR_EMIT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_beat(input logic idle, input logic [7:0] b);
        line_q.push_back({idle, b});
    endtask

    task automatic add_supervisory(input logic [7:0] a, input logic [7:0] c);
        add_beat(1'b0, FLAG_BYTE);
        add_beat(1'b0, a);
        add_beat(1'b0, c);
        add_beat(1'b0, 8'h00 - FLAG_BYTE - a - c - FLAG_BYTE);
        add_beat(1'b0, FLAG_BYTE);
    endtask

    // header, stuffed body, trailer and closing flag
    task automatic add_data_frame(input logic [7:0] a, input logic [7:0] c,
                                  input int units, input int fe_pct);
        logic [7:0] sum;
        logic [7:0] u;
        sum = 8'h00;
        add_beat(1'b0, FLAG_BYTE);
        add_beat(1'b0, a);
        add_beat(1'b0, c);
        add_beat(1'b0, header_check(a, c));
        for (int i = 0; i < units; i++)
        begin
            if ($urandom_range(1, 100) <= fe_pct)
                u = FLAG_BYTE;
            else
            begin
                u = 8'($urandom_range(0, 255));
                if (u == FLAG_BYTE)
                    u = 8'hFF;
            end
            if (u == FLAG_BYTE)
            begin
                add_beat(1'b0, FLAG_BYTE);
                add_beat(1'b0, ESC_BYTE);
                sum = sum + FLAG_BYTE + ESC_BYTE;
            end
            else
            begin
                add_beat(1'b0, u);
                sum = sum + u;
            end
        end
        // a trailer of 0xFE goes out raw and is rescued by the double flag
        add_beat(1'b0, 8'h00 - sum);
        add_beat(1'b0, FLAG_BYTE);
    endtask

    task automatic add_closer();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1))
            add_beat(1'b1, b);
        else
        begin
            if (b == FLAG_BYTE || b == ESC_BYTE)
                b = 8'h00;
            add_beat(1'b0, b);
        end
    endtask

    task automatic send_beat(input logic idle, input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        line_idle <= idle;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        beats_sent++;
    endtask

    task automatic send_line();
        logic [8:0] w;
        while (line_q.size() > 0)
        begin
            w = line_q.pop_front();
            send_beat(w[8], w[7:0]);
        end
    endtask

    initial
    begin : stimulus
        int         start_beats;
        int         frame_no;
        int         pick;
        int         k;
        logic [7:0] a;
        logic [7:0] c;
        logic [7:0] flip;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hunting: idle mark and a stray byte are ignored
        add_beat(1'b1, 8'hFF);
        add_beat(1'b0, 8'h00);
        add_supervisory(ADDR_EMIT, C_SET);
        add_beat(1'b1, 8'h00);
        // escaped 0xFE in the body, closed by 0xFF
        add_data_frame(ADDR_EMIT, 8'hFF, 1, 100);
        add_beat(1'b0, 8'hFF);
        // trailer equal to 0xFE, carried by a double flag
        add_beat(1'b0, FLAG_BYTE);
        add_beat(1'b0, ADDR_EMIT);
        add_beat(1'b0, 8'h00);
        add_beat(1'b0, header_check(ADDR_EMIT, 8'h00));
        add_beat(1'b0, 8'h02);
        add_beat(1'b0, FLAG_BYTE);
        add_beat(1'b0, FLAG_BYTE);
        add_beat(1'b0, 8'h01);
        // timeout inside a frame with no closing flag
        add_beat(1'b0, FLAG_BYTE);
        add_beat(1'b0, ADDR_PEER);
        add_beat(1'b1, 8'h5A);
        send_line();

        start_beats = beats_sent;
        frame_no    = 0;
        while (beats_sent - start_beats < RANDOM_BEATS)
        begin
            calm <= (frame_no >= 60 && frame_no < 100);
            if (frame_no == 20 || frame_no == 110)
                hold_asked <= hold_asked + 1;

            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                a = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : ADDR_EMIT;
                c = 8'($urandom_range(0, 255));
                if (pick < 40 || pick >= 60)
                begin
                    add_data_frame(a, c, $urandom_range(0, 12), 12);
                    add_closer();
                end
                else
                begin
                    case ($urandom_range(0, 8))
                        0:       add_supervisory(ADDR_PEER, C_UA);
                        1:       add_supervisory(ADDR_PEER, C_DISC);
                        2:       add_supervisory(ADDR_PEER, C_RR1);
                        3:       add_supervisory(ADDR_PEER, C_RR0);
                        4:       add_supervisory(ADDR_EMIT, C_DISC);
                        5:       add_supervisory(ADDR_EMIT, C_UA);
                        6:       add_supervisory(ADDR_EMIT, C_SET);
                        7:       add_supervisory(ADDR_PEER, C_SET);
                        default: add_supervisory(a, c);
                    endcase
                    add_closer();
                end
                if (pick >= 60)
                begin
                    // one damaged byte somewhere in the frame or its closer
                    k    = $urandom_range(0, line_q.size() - 1);
                    flip = 8'($urandom_range(1, 255));
                    line_q[k] = {line_q[k][8], line_q[k][7:0] ^ flip};
                end
            end
            else if (pick < 80)
            begin
                // burst cut short by a timeout
                add_data_frame(ADDR_EMIT, 8'($urandom_range(0, 255)),
                               $urandom_range(0, 8), 12);
                k = $urandom_range(1, line_q.size() - 1);
                while (line_q.size() > k)
                    void'(line_q.pop_back());
                add_beat(1'b1, 8'($urandom_range(0, 255)));
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 8))
                    add_beat($urandom_range(0, 5) == 0, skewed_byte());
            end
            else
            begin
                // short or odd frames, escapes in the header
                add_beat(1'b0, FLAG_BYTE);
                repeat ($urandom_range(0, 6))
                    add_beat(1'b0, skewed_byte());
                add_beat(1'b0, FLAG_BYTE);
                add_closer();
            end
            send_line();
            frame_no++;
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
